// ===== hdl/integer_literal_parser_assert.svh =====
// Assertion macros shared by the integer literal parser RTL.
// Each expects clk and rst_n in scope at the point of use.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define ILP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ilp_pkg.sv =====
// Shared types and character constants for the integer literal parser.
// No dependencies.
`timescale 1ns / 1ps

package ilp_pkg;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_BIN = 2'd2,
        BASE_OCT = 2'd3
    } base_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;

    localparam int unsigned VALUE_W = 64;

    // One parsed literal as it leaves the core.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               negative;
        logic [1:0]         base_code;
        logic               format_error;
    } result_t;

endpackage

// ===== hdl/ilp_digit_decode.sv =====
// Character to digit decoder for a given base.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_digit_decode (
    input  logic [7:0]     ch,
    input  ilp_pkg::base_t base,
    output logic           digit_ok,
    output logic [3:0]     digit
);
    import ilp_pkg::*;

    logic is_dec;
    logic is_hex_letter;

    always_comb
    begin
        is_dec        = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_hex_letter = ((ch >= CH_LO_A) && (ch <= CH_LO_F))
                     || ((ch >= CH_UP_A) && (ch <= CH_UP_F));
        // letters a-f / A-F have low nibble 1..6, digit value is nibble + 9
        digit = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
        case (base)
            BASE_HEX: digit_ok = is_dec || is_hex_letter;
            BASE_BIN: digit_ok = is_dec && (ch[3:0] <= 4'd1);
            BASE_OCT: digit_ok = is_dec && (ch[3:0] <= 4'd7);
            default:  digit_ok = is_dec;
        endcase
    end

endmodule

// ===== hdl/ilp_parse_core.sv =====
// Parser state and per-character update; presents the result for a terminator.
// Depends on ilp_pkg and ilp_digit_decode.
`timescale 1ns / 1ps

module ilp_parse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       ch,
    output ilp_pkg::result_t result
);
    import ilp_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                sign_reg, sign_next;
    base_t               base_reg, base_next;
    logic                malformed_reg, malformed_next;
    logic                digit_seen_reg, digit_seen_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;

    base_t               body_base;
    logic                digit_ok;
    logic [3:0]          digit;
    logic [VALUE_W-1:0]  acc_shifted;
    logic                do_body;
    logic                err;

    // the character after a leading zero is judged as octal
    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST: body_base = BASE_DEC;
            PH_ZERO:  body_base = BASE_OCT;
            default:  body_base = base_reg;
        endcase
    end

    ilp_digit_decode u_decode (
        .ch       (ch),
        .base     (body_base),
        .digit_ok (digit_ok),
        .digit    (digit)
    );

    always_comb
    begin
        case (body_base)
            BASE_HEX: acc_shifted = acc_reg << 4;
            BASE_BIN: acc_shifted = acc_reg << 1;
            BASE_OCT: acc_shifted = acc_reg << 3;
            default:  acc_shifted = (acc_reg << 3) + (acc_reg << 1);
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        sign_next       = sign_reg;
        base_next       = base_reg;
        malformed_next  = malformed_reg;
        digit_seen_next = digit_seen_reg;
        acc_next        = acc_reg;
        do_body         = 1'b0;

        unique case (phase_reg)
            PH_FIRST:
            begin
                base_next = BASE_DEC;
                if (ch == CH_ZERO)
                begin
                    phase_next      = PH_ZERO;
                    digit_seen_next = 1'b1;
                end
                else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                begin
                    sign_next  = (ch == CH_MINUS);
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            end
            PH_ZERO:
            begin
                phase_next      = PH_BODY;
                digit_seen_next = 1'b0;
                if ((ch == CH_LO_X) || (ch == CH_UP_X))
                    base_next = BASE_HEX;
                else if ((ch == CH_LO_B) || (ch == CH_UP_B))
                    base_next = BASE_BIN;
                else
                begin
                    base_next = BASE_OCT;
                    do_body   = 1'b1;
                end
            end
            default:
                do_body = 1'b1;
        endcase

        if (do_body && !malformed_reg)
        begin
            if (!digit_ok)
                malformed_next = 1'b1;
            else
            begin
                acc_next        = acc_shifted + {{(VALUE_W-4){1'b0}}, digit};
                digit_seen_next = 1'b1;
            end
        end
    end

    // result as seen by a terminator arriving now
    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST: err = 1'b1;
            PH_ZERO:  err = 1'b0;
            default:  err = malformed_reg || !digit_seen_reg;
        endcase
        result.negative     = sign_reg;
        result.format_error = err;
        result.base_code    = err ? BASE_DEC : base_reg;
        if (err)
            result.value = '0;
        else if ((base_reg == BASE_DEC) && sign_reg)
            result.value = ~acc_reg + {{(VALUE_W-1){1'b0}}, 1'b1};
        else
            result.value = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            sign_reg       <= 1'b0;
            base_reg       <= BASE_DEC;
            malformed_reg  <= 1'b0;
            digit_seen_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else if (step)
        begin
            if (ch == CH_NUL)
            begin
                phase_reg      <= PH_FIRST;
                sign_reg       <= 1'b0;
                base_reg       <= BASE_DEC;
                malformed_reg  <= 1'b0;
                digit_seen_reg <= 1'b0;
                acc_reg        <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                sign_reg       <= sign_next;
                base_reg       <= base_next;
                malformed_reg  <= malformed_next;
                digit_seen_reg <= digit_seen_next;
                acc_reg        <= acc_next;
            end
        end
    end

endmodule

// ===== hdl/integer_literal_parser.sv =====
// Integer literal parser, one character per transfer, one result per terminator.
// Path: input register, state update, result register, then the result port.
// Throughput: 1 character per cycle, except while in_stall is high.
// Non-terminator characters keep flowing while a finished result waits to be taken.
// rst_n (async, active low) clears parser state and both valid flags.
// Depends on ilp_pkg, ilp_parse_core and integer_literal_parser_assert.svh.
`timescale 1ns / 1ps
`include "integer_literal_parser_assert.svh"

module integer_literal_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic        negative,
    output logic [1:0]  base_code,
    output logic        format_error
);
    import ilp_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_ch_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg;
    result_t    core_result;

    logic s1_term;
    logic out_free;
    logic s1_adv;
    logic in_accept;

    assign s1_term   = (s1_ch_reg == CH_NUL);
    assign out_free  = !out_valid_reg || !out_stall;
    // only a terminator needs room in the result register
    assign s1_adv    = s1_valid_reg && (!s1_term || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    ilp_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .ch     (s1_ch_reg),
        .result (core_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_term)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_ch_reg <= ch;
        if (s1_adv && s1_term)
            out_result_reg <= core_result;
    end

    assign out_valid    = out_valid_reg;
    assign value        = out_result_reg.value;
    assign negative     = out_result_reg.negative;
    assign base_code    = out_result_reg.base_code;
    assign format_error = out_result_reg.format_error;

    `ILP_ASSERT_IMPLIES(a_err_clears,
        out_valid_reg && out_result_reg.format_error,
        (out_result_reg.value == '0) && (out_result_reg.base_code == BASE_DEC),
        "error result carries nonzero value or base")
    `ILP_ASSERT_IMPLIES(a_sign_decimal,
        out_valid_reg && out_result_reg.negative && !out_result_reg.format_error,
        out_result_reg.base_code == BASE_DEC,
        "signed literal reported with non-decimal base")
    `ILP_ASSERT_NEXT(a_term_lands, s1_adv && s1_term, out_valid_reg,
        "terminator consumed but no result registered")
    `ILP_ASSERT_NEXT(a_s1_held, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_ch_reg),
        "blocked character lost from input register")

endmodule
